// ===== hw/rtl/sfr_pkg.sv =====
// shared types, constants, tables and round functions of the safer-style cbc cipher
// no dependencies; used by every module of the block
package sfr_pkg;

   localparam int ROUND_COUNT_DEF = 12;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 64;

   typedef enum logic [1:0] {
      REG_MODE      = 2'd0,
      REG_KEY_UPPER = 2'd1,
      REG_KEY_LOWER = 2'd2,
      REG_IV        = 2'd3
   } reg_idx_type;

   localparam logic [63:0] SK_BASE  = 64'hb7e151628aed2a6b;
   localparam logic [63:0] SK_STEP  = 64'h7f4a7c159e3779b9;
   localparam logic [63:0] KEY_STEP = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] IV_RESET = 64'h0101010101010101;

   // lanes 0, 3, 4 and 7 use xor in the first key mix
   localparam logic [7:0] XOR_LANE = 8'b1001_1001;

   typedef logic [0:255][7:0] tbl_type;
   typedef logic [0:7][7:0] blk_type;

   typedef struct packed {
      logic load;
      logic step;
      logic final_mix;
      logic finish;
      logic dec;
   } cmd_type;

   function automatic tbl_type build_exp();
      tbl_type t;
      int p;
      p = 1;
      for (int x = 0; x < 256; x++) begin
         t[x] = 8'(p);
         p = (p * 45) % 257;
      end
      return t;
   endfunction

   localparam tbl_type EXP_TBL = build_exp();

   function automatic tbl_type build_log();
      tbl_type t;
      t = '0;
      for (int x = 0; x < 256; x++) begin
         t[EXP_TBL[x]] = 8'(x);
      end
      return t;
   endfunction

   localparam tbl_type LOG_TBL = build_log();

   function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] s);
      logic [127:0] w;
      w = {x, x} << s;
      return w[127:64];
   endfunction

   function automatic blk_type key_mix(input blk_type c, input blk_type k,
                                       input logic sel, input logic neg);
      blk_type r;
      for (int i = 0; i < 8; i++) begin
         if (XOR_LANE[i] == sel) r[i] = c[i] ^ k[i];
         else if (neg) r[i] = c[i] - k[i];
         else r[i] = c[i] + k[i];
      end
      return r;
   endfunction

   function automatic blk_type pht(input blk_type c);
      blk_type r;
      for (int i = 0; i < 8; i += 2) begin
         r[i]   = 8'({c[i], 1'b0} + {1'b0, c[i+1]});
         r[i+1] = c[i] + c[i+1];
      end
      return r;
   endfunction

   function automatic blk_type ipht(input blk_type c);
      blk_type r;
      for (int i = 0; i < 8; i += 2) begin
         r[i]   = c[i] - c[i+1];
         r[i+1] = c[i+1] - r[i];
      end
      return r;
   endfunction

   function automatic blk_type shuffle(input blk_type c);
      return {c[0], c[2], c[4], c[6], c[1], c[3], c[5], c[7]};
   endfunction

   function automatic blk_type unshuffle(input blk_type c);
      return {c[0], c[4], c[1], c[5], c[2], c[6], c[3], c[7]};
   endfunction

   function automatic blk_type enc_round(input blk_type c, input blk_type k1,
                                         input blk_type k2);
      blk_type t;
      t = key_mix(c, k1, 1'b1, 1'b0);
      for (int i = 0; i < 8; i++) t[i] = XOR_LANE[i] ? EXP_TBL[t[i]] : LOG_TBL[t[i]];
      t = key_mix(t, k2, 1'b0, 1'b0);
      return pht(shuffle(pht(shuffle(pht(t)))));
   endfunction

   function automatic blk_type dec_round(input blk_type c, input blk_type k1,
                                         input blk_type k2);
      blk_type t;
      t = ipht(unshuffle(ipht(unshuffle(ipht(c)))));
      t = key_mix(t, k2, 1'b0, 1'b1);
      for (int i = 0; i < 8; i++) t[i] = XOR_LANE[i] ? LOG_TBL[t[i]] : EXP_TBL[t[i]];
      return key_mix(t, k1, 1'b1, 1'b1);
   endfunction

endpackage

// ===== hw/rtl/sfr_keysched.sv =====
// subkey schedule: one subkey a cycle from the 128-bit key, kept in odd and even banks
// depends on sfr_pkg
module sfr_keysched #(
   parameter int RC = sfr_pkg::ROUND_COUNT_DEF,
   localparam int KW = $clog2(RC + 1),
   localparam int NW = KW + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              kick,
   input  logic [63:0]       key_upper,
   input  logic [63:0]       key_lower,
   input  logic [KW-1:0]     odd_addr,
   input  logic [KW-1:0]     even_addr,
   output logic [63:0]       odd_key,
   output logic [63:0]       even_key,
   output logic              busy
);
   import sfr_pkg::*;

   localparam logic [NW-1:0] LAST_N = NW'(2 * RC + 1);

   logic [63:0] odd_bank_ff [RC+1];
   logic [63:0] even_bank_ff [RC+1];
   logic [63:0] odd_key_ff, even_key_ff;
   logic        busy_ff, busy_in;
   logic [NW-1:0] n_ff, n_in;
   logic [63:0] a_ff, a_in, b_ff, b_in, s_run_ff, s_run_in, lk_run_ff, lk_run_in;
   logic [63:0] lk_cur, s_new, ab;

   always_comb begin
      lk_cur   = (n_ff == '0) ? key_upper : lk_run_ff;
      s_new    = rotl64(s_run_ff + a_ff + b_ff, 6'd3);
      ab       = s_new + b_ff;
      busy_in  = busy_ff;
      n_in     = n_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      s_run_in = s_run_ff;
      lk_run_in = lk_run_ff;
      if (kick) begin
         busy_in   = 1'b1;
         n_in      = '0;
         a_in      = '0;
         b_in      = '0;
         s_run_in  = SK_BASE;
         lk_run_in = key_lower;
      end else if (busy_ff) begin
         a_in     = s_new;
         b_in     = rotl64(lk_cur + ab, ab[5:0]);
         s_run_in = s_run_ff + SK_STEP;
         if (n_ff != '0) lk_run_in = lk_run_ff + KEY_STEP;
         n_in     = n_ff + NW'(1);
         if (n_ff == LAST_N) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         n_ff      <= '0;
         a_ff      <= '0;
         b_ff      <= '0;
         s_run_ff  <= SK_BASE;
         lk_run_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         n_ff      <= n_in;
         a_ff      <= a_in;
         b_ff      <= b_in;
         s_run_ff  <= s_run_in;
         lk_run_ff <= lk_run_in;
      end
   end

   // addresses are those of the next cycle, so the subkeys arrive registered
   always_ff @(posedge clock) begin
      if (busy_ff && !kick) begin
         if (n_ff[0]) odd_bank_ff[n_ff[NW-1:1]] <= s_new;
         else even_bank_ff[n_ff[NW-1:1]] <= s_new;
      end
      odd_key_ff  <= odd_bank_ff[odd_addr];
      even_key_ff <= even_bank_ff[even_addr];
   end

   assign odd_key  = odd_key_ff;
   assign even_key = even_key_ff;
   assign busy     = busy_ff;

endmodule

// ===== hw/rtl/sfr_ctrl.sv =====
// controller: accepts blocks, sequences the rounds and owns the result valid
// depends on sfr_pkg
module sfr_ctrl #(
   parameter int RC = sfr_pkg::ROUND_COUNT_DEF,
   localparam int KW = $clog2(RC + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                ks_ready,
   input  logic                dec_mode,
   output sfr_pkg::cmd_type    cmd,
   output logic [KW-1:0]       odd_addr,
   output logic [KW-1:0]       even_addr
);
   import sfr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   localparam logic [KW-1:0] LAST = KW'(RC);

   state_type     state_ff, state_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic          dec_ff, dec_in, rsp_valid_ff, rsp_valid_in;
   logic          last, out_free, nxt_last;

   always_comb begin
      last     = cnt_ff == LAST;
      out_free = !rsp_valid_ff || rsp_ready;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dec_in   = dec_ff;
      req_ready = 1'b0;
      cmd      = '0;
      cmd.dec  = dec_ff;
      cmd.final_mix = dec_ff ? (cnt_ff == '0) : last;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = ks_ready;
            if (req_valid && ks_ready) begin
               cmd.load = 1'b1;
               cmd.dec  = dec_mode;
               dec_in   = dec_mode;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!last) begin
               cmd.step = 1'b1;
               cnt_in   = cnt_ff + KW'(1);
            end else if (out_free) begin
               cmd.step   = 1'b1;
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // subkey addresses for the next cycle
      nxt_last = cnt_in == LAST;
      if (dec_in) begin
         if (cnt_in == '0) begin
            odd_addr  = LAST;
            even_addr = LAST;
         end else begin
            odd_addr  = LAST - cnt_in;
            even_addr = LAST - cnt_in + KW'(1);
         end
      end else begin
         odd_addr  = cnt_in;
         even_addr = nxt_last ? cnt_in : cnt_in + KW'(1);
      end
      rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         dec_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/sfr_datapath.sv =====
// datapath: block state, cbc chain value, round logic and result register
// depends on sfr_pkg
module sfr_datapath (
   input  logic              clock,
   input  logic              reset,
   input  sfr_pkg::cmd_type  cmd,
   input  logic [63:0]       block_in,
   input  logic              message_start,
   input  logic [63:0]       init_vector,
   input  logic [63:0]       odd_key,
   input  logic [63:0]       even_key,
   output logic [63:0]       block_out
);
   import sfr_pkg::*;

   blk_type     state_ff, state_in;
   logic [63:0] chain_ff, chain_in, save_ff, save_in, out_ff, out_in, chain_use, result;

   always_comb begin
      chain_use = message_start ? init_vector : chain_ff;
      state_in  = state_ff;
      chain_in  = chain_ff;
      save_in   = save_ff;
      out_in    = out_ff;
      if (cmd.load) begin
         chain_in = chain_use;
         save_in  = block_in;
         state_in = cmd.dec ? block_in : block_in ^ chain_use;
      end else if (cmd.step) begin
         if (cmd.final_mix) state_in = key_mix(state_ff, odd_key, 1'b1, cmd.dec);
         else if (cmd.dec) state_in = dec_round(state_ff, odd_key, even_key);
         else state_in = enc_round(state_ff, odd_key, even_key);
      end
      result = cmd.dec ? (64'(state_in) ^ chain_ff) : 64'(state_in);
      if (cmd.finish) begin
         out_in   = result;
         chain_in = cmd.dec ? save_ff : result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) chain_ff <= IV_RESET;
      else chain_ff <= chain_in;
      state_ff <= state_in;
      save_ff  <= save_in;
      out_ff   <= out_in;
   end

   assign block_out = out_ff;

endmodule

// ===== hw/rtl/safer_like_block_cipher_cbc_core.sv =====
// top level of the safer-style 64-bit cipher in cbc mode with apb register port
// depends on sfr_pkg, sfr_keysched, sfr_ctrl, sfr_datapath
//
//   channel   handshake               payload
//   req       req_valid/req_ready     req_block_in, req_message_start
//   rsp       rsp_valid/rsp_ready     rsp_block_out
//   csr       psel/penable/pready     paddr, pwrite, pwdata, prdata
//
// a block is taken in a transfer cycle, then runs its RC rounds and one key mix on one round unit
// after reset and after each key write the subkey schedule computes all 2*RC+2 subkeys;
// req_ready stays low meanwhile
// a result waiting on rsp holds the last round; the next block is taken once it is stored
module safer_like_block_cipher_cbc_core #(
   parameter int ROUND_COUNT = sfr_pkg::ROUND_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [63:0]               req_block_in,
   input  logic                      req_message_start,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [63:0]               rsp_block_out,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [sfr_pkg::ADDR_W-1:0] paddr,
   input  logic [sfr_pkg::DATA_W-1:0] pwdata,
   output logic [sfr_pkg::DATA_W-1:0] prdata,
   output logic                      pready
);
   import sfr_pkg::*;

   localparam int KW = $clog2(ROUND_COUNT + 1);

   logic        dec_mode_ff, dec_mode_in, kick_ff, kick_in;
   logic [63:0] key_upper_ff, key_upper_in, key_lower_ff, key_lower_in, iv_ff, iv_in;
   logic        wr, ks_busy, ks_ready;
   reg_idx_type idx;
   cmd_type     cmd;
   logic [KW-1:0] odd_addr, even_addr;
   logic [63:0] odd_key, even_key;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[4:3]);
   assign wr     = psel && penable && pwrite && pready;

   always_comb begin
      dec_mode_in  = dec_mode_ff;
      key_upper_in = key_upper_ff;
      key_lower_in = key_lower_ff;
      iv_in        = iv_ff;
      kick_in      = 1'b0;
      if (wr) begin
         unique case (idx)
            REG_MODE:      dec_mode_in = pwdata[0];
            REG_KEY_UPPER: begin
               key_upper_in = pwdata;
               kick_in      = 1'b1;
            end
            REG_KEY_LOWER: begin
               key_lower_in = pwdata;
               kick_in      = 1'b1;
            end
            REG_IV:        iv_in = pwdata;
            default:       ;
         endcase
      end
      unique case (idx)
         REG_MODE:      prdata = {63'd0, dec_mode_ff};
         REG_KEY_UPPER: prdata = key_upper_ff;
         REG_KEY_LOWER: prdata = key_lower_ff;
         REG_IV:        prdata = iv_ff;
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_mode_ff  <= 1'b0;
         key_upper_ff <= '0;
         key_lower_ff <= '0;
         iv_ff        <= IV_RESET;
         kick_ff      <= 1'b0;
      end else begin
         dec_mode_ff  <= dec_mode_in;
         key_upper_ff <= key_upper_in;
         key_lower_ff <= key_lower_in;
         iv_ff        <= iv_in;
         kick_ff      <= kick_in;
      end
   end

   assign ks_ready = !ks_busy && !kick_ff && !kick_in;

   sfr_keysched #(.RC(ROUND_COUNT)) u_keysched (
      .clock     (clock),
      .reset     (reset),
      .kick      (kick_ff),
      .key_upper (key_upper_ff),
      .key_lower (key_lower_ff),
      .odd_addr  (odd_addr),
      .even_addr (even_addr),
      .odd_key   (odd_key),
      .even_key  (even_key),
      .busy      (ks_busy)
   );

   sfr_ctrl #(.RC(ROUND_COUNT)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ks_ready  (ks_ready),
      .dec_mode  (dec_mode_ff),
      .cmd       (cmd),
      .odd_addr  (odd_addr),
      .even_addr (even_addr)
   );

   sfr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .block_in      (req_block_in),
      .message_start (req_message_start),
      .init_vector   (iv_ff),
      .odd_key       (odd_key),
      .even_key      (even_key),
      .block_out     (rsp_block_out)
   );

endmodule

// ===== hw/rtl/sfr_checker.sv =====
// port-level checks of the cipher core, attached by bind
// depends on sfr_pkg and safer_like_block_cipher_cbc_core ports only
module sfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_block_out,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [4:0]  paddr
);
   import sfr_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_out))
      else $error("result changed while stalled");

   // one block at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer while busy");

   // key write restarts the schedule
   a_key_blocks: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && (reg_idx_type'(paddr[4:3]) == REG_KEY_UPPER ||
                                    reg_idx_type'(paddr[4:3]) == REG_KEY_LOWER)
      |=> !req_ready)
      else $error("input taken during key schedule");

   // no result right after a transfer
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result too early");

endmodule

bind safer_like_block_cipher_cbc_core sfr_checker u_sfr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_block_out (rsp_block_out),
   .psel          (psel),
   .penable       (penable),
   .pwrite        (pwrite),
   .paddr         (paddr)
);

// ===== sim/testbench.sv =====
// self-checking testbench for the safer-style 64-bit cbc cipher core
// depends on sfr_pkg and safer_like_block_cipher_cbc_core; carries its own cipher and key schedule
// to predict every block, then checks each rsp transfer against it
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sfr_pkg::*;

   localparam int ROUNDS = ROUND_COUNT_DEF;
   localparam int NKEYS = 2 * ROUNDS + 2;
   localparam logic [63:0] SCHED_BASE = 64'hb7e151628aed2a6b;
   localparam logic [63:0] SCHED_STEP = 64'h7f4a7c159e3779b9;
   localparam logic [63:0] KEY_INC = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] IV_AT_RESET = 64'h0101010101010101;
   localparam int CYCLE_LIMIT = 400000;

   typedef logic [0:7][7:0] octets_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [63:0] req_block_in = '0;
   logic req_message_start = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [63:0] rsp_block_out;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   safer_like_block_cipher_cbc_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model state
   logic [7:0] pow_tbl [256];
   logic [7:0] log_tbl [256];
   logic [63:0] subkeys [NKEYS];
   logic dec_on;
   logic [63:0] key_hi, key_lo, iv_reg, chain;

   logic [63:0] expected_blocks [$];
   int errors = 0;
   int blocks_sent = 0;
   int blocks_checked = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycles = 0;

   function automatic logic [63:0] rot_left(logic [63:0] x, logic [5:0] s);
      if (s == 0) return x;
      return (x << s) | (x >> (7'd64 - s));
   endfunction

   function automatic bit is_xor_lane(int i);
      return i == 0 || i == 3 || i == 4 || i == 7;
   endfunction

   task automatic fill_tables();
      int p;
      p = 1;
      for (int x = 0; x < 256; x++) begin
         pow_tbl[x] = 8'(p);
         log_tbl[8'(p)] = 8'(x);
         p = (p * 45) % 257;
      end
   endtask

   task automatic expand_key();
      logic [63:0] lk [NKEYS];
      logic [63:0] a, b;
      lk[0] = key_hi;
      lk[1] = key_lo;
      for (int n = 2; n < NKEYS; n++) lk[n] = lk[n-1] + KEY_INC;
      subkeys[0] = SCHED_BASE;
      for (int n = 1; n < NKEYS; n++) subkeys[n] = subkeys[n-1] + SCHED_STEP;
      a = '0;
      b = '0;
      for (int n = 0; n < NKEYS; n++) begin
         subkeys[n] = rot_left(subkeys[n] + a + b, 6'd3);
         a = subkeys[n];
         lk[n] = rot_left(lk[n] + a + b, 6'(a + b));
         b = lk[n];
      end
   endtask

   function automatic octets_type mix(octets_type c, logic [63:0] key, bit sel, bit neg);
      octets_type k;
      k = key;
      for (int i = 0; i < 8; i++) begin
         if (is_xor_lane(i) == sel) c[i] = c[i] ^ k[i];
         else if (neg) c[i] = c[i] - k[i];
         else c[i] = c[i] + k[i];
      end
      return c;
   endfunction

   function automatic octets_type hadamard(octets_type c, bit inv);
      logic [7:0] a, b;
      for (int i = 0; i < 8; i += 2) begin
         if (inv) begin
            a = c[i] - c[i+1];
            b = c[i+1] - a;
         end else begin
            a = 8'(2 * c[i] + c[i+1]);
            b = c[i] + c[i+1];
         end
         c[i] = a;
         c[i+1] = b;
      end
      return c;
   endfunction

   function automatic octets_type permute(octets_type c, bit inv);
      if (inv) return {c[0], c[4], c[1], c[5], c[2], c[6], c[3], c[7]};
      return {c[0], c[2], c[4], c[6], c[1], c[3], c[5], c[7]};
   endfunction

   function automatic logic [63:0] encipher(logic [63:0] v);
      octets_type c;
      c = v;
      for (int r = 1; r <= ROUNDS; r++) begin
         c = mix(c, subkeys[2*r-1], 1'b1, 1'b0);
         for (int i = 0; i < 8; i++) c[i] = is_xor_lane(i) ? pow_tbl[c[i]] : log_tbl[c[i]];
         c = mix(c, subkeys[2*r], 1'b0, 1'b0);
         c = hadamard(permute(hadamard(permute(hadamard(c, 1'b0), 1'b0), 1'b0), 1'b0),
                      1'b0);
      end
      c = mix(c, subkeys[NKEYS-1], 1'b1, 1'b0);
      return c;
   endfunction

   function automatic logic [63:0] decipher(logic [63:0] v);
      octets_type c;
      c = v;
      c = mix(c, subkeys[NKEYS-1], 1'b1, 1'b1);
      for (int r = ROUNDS; r >= 1; r--) begin
         c = hadamard(permute(hadamard(permute(hadamard(c, 1'b1), 1'b1), 1'b1), 1'b1),
                      1'b1);
         c = mix(c, subkeys[2*r], 1'b0, 1'b1);
         for (int i = 0; i < 8; i++) c[i] = is_xor_lane(i) ? log_tbl[c[i]] : pow_tbl[c[i]];
         c = mix(c, subkeys[2*r-1], 1'b1, 1'b1);
      end
      return c;
   endfunction

   task automatic predict_cbc(logic [63:0] blk, logic start);
      logic [63:0] res;
      if (start) chain = iv_reg;
      if (dec_on) begin
         res = decipher(blk) ^ chain;
         chain = blk;
      end else begin
         res = encipher(blk ^ chain);
         chain = res;
      end
      expected_blocks.push_back(res);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // one transfer on req; valid stays high into the next call unless a gap is drawn
   task automatic send_block(logic [63:0] blk, logic start);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_block_in = blk;
      req_message_start = start;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_cbc(blk, start);
      blocks_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (expected_blocks.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, logic [63:0] value);
      wait_idle();
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = ADDR_W'(8 * int'(idx));
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_MODE: dec_on = value[0];
         REG_KEY_UPPER: begin
            key_hi = value;
            expand_key();
         end
         REG_KEY_LOWER: begin
            key_lo = value;
            expand_key();
         end
         default: iv_reg = value;
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles", $time, cycles);
         $display("Regression FAIL");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t unexpected block %h", $time, rsp_block_out);
            errors++;
         end else begin
            if (rsp_block_out !== expected_blocks[0]) begin
               $display("%0t block_out mismatch: expected %h actual %h",
                        $time, expected_blocks[0], rsp_block_out);
               errors++;
            end
            void'(expected_blocks.pop_front());
            blocks_checked++;
         end
      end
   end

   task automatic test_directed();
      send_block(64'h0, 1'b1);
      send_block(64'hffff_ffff_ffff_ffff, 1'b0);
      send_block(64'h8000_0000_0000_0001, 1'b0);
      // a new iv only takes effect at the next message start
      write_reg(REG_IV, 64'hffff_ffff_ffff_ffff);
      send_block(64'h0123_4567_89ab_cdef, 1'b0);
      send_block(64'h0123_4567_89ab_cdef, 1'b1);
      write_reg(REG_KEY_UPPER, 64'hffff_ffff_ffff_ffff);
      write_reg(REG_KEY_LOWER, 64'hffff_ffff_ffff_ffff);
      send_block(64'h0, 1'b1);
      send_block(64'hffff_ffff_ffff_ffff, 1'b0);
      // mode switch in the middle of a message keeps the chain
      write_reg(REG_MODE, 64'd1);
      send_block(64'h5555_aaaa_5555_aaaa, 1'b0);
      send_block(64'h0, 1'b1);
      send_block(64'hffff_ffff_ffff_ffff, 1'b0);
      write_reg(REG_IV, 64'h0);
      write_reg(REG_KEY_LOWER, 64'h0);
      send_block(64'hdead_beef_0000_ffff, 1'b1);
      send_block(64'h0, 1'b0);
      write_reg(REG_MODE, 64'd0);
      write_reg(REG_KEY_UPPER, 64'h0);
      send_block(64'haaaa_5555_aaaa_5555, 1'b0);
      send_block(64'h0, 1'b1);
   endtask

   // an encrypt message followed by a decrypt message, both with random content
   task automatic test_random_phase(int send_pct, int recv_pct, int items);
      logic [63:0] plain [$];
      int len;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      while (items > 0) begin
         write_reg(REG_KEY_UPPER, rand64());
         write_reg(REG_KEY_LOWER, rand64());
         write_reg(REG_IV, rand64());
         for (int m = 0; m < 3 && items > 0; m++) begin
            write_reg(REG_MODE, 64'd0);
            len = $urandom_range(1, 12);
            plain.delete();
            for (int i = 0; i < len; i++) begin
               plain.push_back(rand64());
               send_block(plain[i], i == 0 || $urandom_range(15) == 0);
            end
            write_reg(REG_MODE, 64'd1);
            for (int i = 0; i < len; i++) send_block(rand64(), i == 0 || $urandom_range(7) == 0);
            items -= 2 * len;
         end
      end
      wait_idle();
   endtask

   initial begin
      fill_tables();
      dec_on = 1'b0;
      key_hi = '0;
      key_lo = '0;
      iv_reg = IV_AT_RESET;
      chain = IV_AT_RESET;
      expand_key();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_phase(0, 0, 140);
      test_random_phase(53, 0, 130);
      test_random_phase(0, 53, 130);
      test_random_phase(36, 36, 130);
      wait_idle();
      $display("covered %0d blocks, %0d checked, encrypt and decrypt with key, iv and mode changes",
               blocks_sent, blocks_checked);
      $display("idle phases: none, sender gaps, receiver stalls, both");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== safer_like_block_cipher_cbc_core.f =====
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_keysched.sv
hw/rtl/sfr_ctrl.sv
hw/rtl/sfr_datapath.sv
hw/rtl/safer_like_block_cipher_cbc_core.sv
hw/rtl/sfr_checker.sv
sim/testbench.sv
